// File: rtl/tclf_pkg.sv
// Shared types and codes of the trace cache lookup and fill core.
`default_nettype none
package tclf_pkg;

    typedef enum logic {
        KIND_PLAIN  = 1'b0,
        KIND_BRANCH = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] fetch_addr;
        logic        branch_pred;
    } item_t;

    typedef struct packed {
        logic [5:0]  limit;
        logic        seed_load;
        logic [15:0] seed;
    } cfg_t;

    typedef struct packed {
        logic        looked_up;
        logic        hit;
        logic [5:0]  hit_length;
        logic        trace_written;
        logic [7:0]  written_slot;
        logic [5:0]  written_length;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CMT_WR,
        ST_LOOK_RD,
        ST_LOOK_CMP,
        ST_MOD,
        ST_OUT
    } st_t;

    localparam logic [15:0] LFSR_TAPS = 16'hB400;
    localparam int unsigned REG_MAX_INSNS = 0;
    localparam int unsigned REG_LFSR_SEED = 1;

endpackage
`default_nettype wire

// File: rtl/tclf_if.sv
// Valid/ready channel interfaces for fetched instructions and lookup results.
`default_nettype none
interface tclf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] fetch_addr;
    logic        is_branch;
    logic        branch_pred;

    modport source (output valid, output fetch_addr, output is_branch, output branch_pred,
                    input ready);
    modport sink (input valid, input fetch_addr, input is_branch, input branch_pred,
                  output ready);
endinterface

interface tclf_out_if;
    logic        valid;
    logic        ready;
    logic        looked_up;
    logic        hit;
    logic [5:0]  hit_length;
    logic        trace_written;
    logic [7:0]  written_slot;
    logic [5:0]  written_length;
    logic [31:0] hit_total;
    logic [31:0] miss_total;

    modport source (output valid, output looked_up, output hit, output hit_length,
                    output trace_written, output written_slot, output written_length,
                    output hit_total, output miss_total, input ready);
    modport sink (input valid, input looked_up, input hit, input hit_length,
                  input trace_written, input written_slot, input written_length,
                  input hit_total, input miss_total, output ready);
endinterface
`default_nettype wire

// File: rtl/tclf_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module tclf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/tclf_front.sv
// Front end: accepts fetched instructions, classifies them and queues them.
`default_nettype none
module tclf_front (
    input  wire logic     clk,
    input  wire logic     rst_n,
    tclf_in_if.sink       fetch,
    input  wire logic     busy_clear,
    output logic          q_valid,
    output tclf_pkg::item_t q_item,
    input  wire logic     q_pop
);
    tclf_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    tclf_pkg::item_t new_item;

    assign fetch.ready = (count_reg != 2'd2) && !busy_clear;
    assign push = fetch.valid && fetch.ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.kind = fetch.is_branch ? tclf_pkg::KIND_BRANCH : tclf_pkg::KIND_PLAIN;
        new_item.fetch_addr = fetch.fetch_addr;
        new_item.branch_pred = fetch.branch_pred;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end
endmodule
`default_nettype wire

// File: rtl/tclf_back.sv
// Back end: sequences commits, lookups and replacement over the line memories.
`default_nettype none
module tclf_back #(
    parameter int SETS      = 64,
    parameter int WAYS      = 4,
    parameter int ADDR_BITS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire tclf_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 busy_clear,
    input  wire tclf_pkg::cfg_t  cfg,
    tclf_out_if.source           result
);
    localparam int SET_BITS = $clog2(SETS + 1) - 1;
    localparam int SET_W    = SET_BITS > 0 ? SET_BITS : 1;
    localparam int NSETS    = 1 << SET_BITS;
    localparam logic [31:0] SET_MASK = 32'((64'd1 << SET_BITS) - 64'd1);
    localparam int TAG_W    = ADDR_BITS < 32 ? ADDR_BITS : 32;
    localparam int WAY_W    = WAYS > 1 ? $clog2(WAYS) : 1;
    localparam int LINE_W   = TAG_W + 7;
    localparam logic [32:0] MOD_MUL = 33'(((64'd1 << 32) + 64'(WAYS) - 64'd1) / 64'(WAYS));

    tclf_pkg::st_t state_reg, state_next;
    logic [31:0]      cur_addr_reg, cur_addr_next;
    logic             cur_branch_reg, cur_branch_next;
    logic             cur_pred_reg, cur_pred_next;
    logic             building_reg, building_next;
    logic [TAG_W-1:0] build_tag_reg, build_tag_next;
    logic             build_pred_reg, build_pred_next;
    logic [5:0]       build_count_reg, build_count_next;
    logic [SET_W-1:0] build_set_reg, build_set_next;
    logic [WAY_W-1:0] build_way_reg, build_way_next;
    logic [31:0]      hit_cnt_reg, hit_cnt_next;
    logic [31:0]      miss_cnt_reg, miss_cnt_next;
    logic [15:0]      lfsr_reg, lfsr_next;
    logic [15:0]      mod_val_reg, mod_val_next;
    logic [SET_W-1:0] clr_reg, clr_next;
    tclf_pkg::res_t   res_reg, res_next;
    tclf_pkg::res_t   out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic [SET_W-1:0]  rd_addr;
    logic              v_we;
    logic [SET_W-1:0]  v_waddr;
    logic [WAYS-1:0]   v_wdata;
    logic [WAYS-1:0]   v_rdata;
    logic [WAYS-1:0]   way_we;
    logic [LINE_W-1:0] way_wdata;
    logic [LINE_W-1:0] way_rdata [WAYS];
    logic [SET_W-1:0]  cur_set;
    logic [TAG_W-1:0]  cur_tag;
    logic              found;
    logic [5:0]        found_len;
    logic              free_any;
    logic [WAY_W-1:0]  free_way;
    logic [48:0]       mod_prod;
    logic [15:0]       mod_quot;
    logic [15:0]       mod_rem;
    logic [15:0]       lfsr_step;
    logic [5:0]        count_inc;

    assign cur_set = SET_W'(cur_addr_reg & SET_MASK);
    assign cur_tag = TAG_W'(cur_addr_reg);
    assign way_wdata = {build_tag_reg, build_pred_reg, build_count_reg};
    assign busy_clear = (state_reg == tclf_pkg::ST_CLEAR);

    // The LFSR value modulo WAYS, by multiplying with the rounded-up reciprocal.
    assign mod_prod = 49'(mod_val_reg) * 49'(MOD_MUL);
    assign mod_quot = 16'(mod_prod >> 32);
    assign mod_rem = mod_val_reg - 16'(32'(mod_quot) * 32'(WAYS));

    tclf_ram #(.WIDTH(WAYS), .DEPTH(NSETS)) u_valid_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (v_wdata),
        .raddr (rd_addr),
        .rdata (v_rdata)
    );

    for (genvar g = 0; g < WAYS; g++)
    begin : g_way
        tclf_ram #(.WIDTH(LINE_W), .DEPTH(NSETS)) u_line_ram (
            .clk   (clk),
            .we    (way_we[g]),
            .waddr (build_set_reg),
            .wdata (way_wdata),
            .raddr (rd_addr),
            .rdata (way_rdata[g])
        );
    end

    assign result.valid          = out_valid_reg;
    assign result.looked_up      = out_reg.looked_up;
    assign result.hit            = out_reg.hit;
    assign result.hit_length     = out_reg.hit_length;
    assign result.trace_written  = out_reg.trace_written;
    assign result.written_slot   = out_reg.written_slot;
    assign result.written_length = out_reg.written_length;
    assign result.hit_total      = out_reg.hit_total;
    assign result.miss_total     = out_reg.miss_total;

    always_comb
    begin
        found = 1'b0;
        found_len = 6'd0;
        free_any = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (v_rdata[w] && way_rdata[w][LINE_W-1:7] == cur_tag
                && way_rdata[w][6] == cur_pred_reg)
            begin
                found = 1'b1;
                found_len = way_rdata[w][5:0];
            end
            if (!v_rdata[w])
            begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_addr_next = cur_addr_reg;
        cur_branch_next = cur_branch_reg;
        cur_pred_next = cur_pred_reg;
        building_next = building_reg;
        build_tag_next = build_tag_reg;
        build_pred_next = build_pred_reg;
        build_count_next = build_count_reg;
        build_set_next = build_set_reg;
        build_way_next = build_way_reg;
        hit_cnt_next = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        lfsr_next = lfsr_reg;
        mod_val_next = mod_val_reg;
        clr_next = clr_reg;
        res_next = res_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;
        q_pop = 1'b0;
        rd_addr = cur_set;
        v_we = 1'b0;
        v_waddr = build_set_reg;
        v_wdata = v_rdata | (WAYS'(1) << build_way_reg);
        way_we = '0;
        lfsr_step = {1'b0, lfsr_reg[15:1]} ^ (lfsr_reg[0] ? tclf_pkg::LFSR_TAPS : 16'h0000);
        count_inc = build_count_reg + 6'd1;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            tclf_pkg::ST_CLEAR:
            begin
                v_we = 1'b1;
                v_waddr = clr_reg;
                v_wdata = '0;
                clr_next = clr_reg + SET_W'(1);
                if (clr_reg == SET_W'(NSETS - 1))
                begin
                    state_next = tclf_pkg::ST_IDLE;
                end
            end
            tclf_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    cur_addr_next = q_item.fetch_addr;
                    cur_branch_next = (q_item.kind == tclf_pkg::KIND_BRANCH);
                    cur_pred_next = q_item.branch_pred;
                    res_next = '0;
                    if (q_item.kind == tclf_pkg::KIND_BRANCH)
                    begin
                        if (building_reg)
                        begin
                            rd_addr = build_set_reg;
                            state_next = tclf_pkg::ST_CMT_WR;
                        end
                        else
                        begin
                            rd_addr = SET_W'(q_item.fetch_addr & SET_MASK);
                            state_next = tclf_pkg::ST_LOOK_CMP;
                        end
                    end
                    else if (building_reg)
                    begin
                        build_count_next = count_inc;
                        rd_addr = build_set_reg;
                        state_next = (count_inc >= cfg.limit) ? tclf_pkg::ST_CMT_WR
                                                              : tclf_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = tclf_pkg::ST_OUT;
                    end
                end
            end
            tclf_pkg::ST_CMT_WR:
            begin
                v_we = 1'b1;
                for (int w = 0; w < WAYS; w++)
                begin
                    way_we[w] = (build_way_reg == WAY_W'(w));
                end
                res_next.trace_written = 1'b1;
                res_next.written_slot = 8'(32'(build_set_reg) * 32'(WAYS)
                                           + 32'(build_way_reg));
                res_next.written_length = build_count_reg;
                building_next = 1'b0;
                build_count_next = 6'd0;
                state_next = cur_branch_reg ? tclf_pkg::ST_LOOK_RD : tclf_pkg::ST_OUT;
            end
            tclf_pkg::ST_LOOK_RD:
            begin
                state_next = tclf_pkg::ST_LOOK_CMP;
            end
            tclf_pkg::ST_LOOK_CMP:
            begin
                res_next.looked_up = 1'b1;
                if (found)
                begin
                    res_next.hit = 1'b1;
                    res_next.hit_length = found_len;
                    hit_cnt_next = hit_cnt_reg + 32'd1;
                    state_next = tclf_pkg::ST_OUT;
                end
                else
                begin
                    miss_cnt_next = miss_cnt_reg + 32'd1;
                    build_set_next = cur_set;
                    build_tag_next = cur_tag;
                    build_pred_next = cur_pred_reg;
                    build_count_next = 6'd1;
                    building_next = 1'b1;
                    if (free_any)
                    begin
                        build_way_next = free_way;
                        state_next = tclf_pkg::ST_OUT;
                    end
                    else
                    begin
                        lfsr_next = lfsr_step;
                        mod_val_next = lfsr_step;
                        state_next = tclf_pkg::ST_MOD;
                    end
                end
            end
            tclf_pkg::ST_MOD:
            begin
                build_way_next = WAY_W'(mod_rem);
                state_next = tclf_pkg::ST_OUT;
            end
            tclf_pkg::ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_next = res_reg;
                    out_next.hit_total = hit_cnt_reg;
                    out_next.miss_total = miss_cnt_reg;
                    out_valid_next = 1'b1;
                    state_next = tclf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tclf_pkg::ST_IDLE;
            end
        endcase

        if (cfg.seed_load)
        begin
            lfsr_next = cfg.seed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tclf_pkg::ST_CLEAR;
            cur_addr_reg <= '0;
            cur_branch_reg <= 1'b0;
            cur_pred_reg <= 1'b0;
            building_reg <= 1'b0;
            build_tag_reg <= '0;
            build_pred_reg <= 1'b0;
            build_count_reg <= '0;
            build_set_reg <= '0;
            build_way_reg <= '0;
            hit_cnt_reg <= '0;
            miss_cnt_reg <= '0;
            lfsr_reg <= 16'd1;
            mod_val_reg <= '0;
            clr_reg <= '0;
            res_reg <= '0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_addr_reg <= cur_addr_next;
            cur_branch_reg <= cur_branch_next;
            cur_pred_reg <= cur_pred_next;
            building_reg <= building_next;
            build_tag_reg <= build_tag_next;
            build_pred_reg <= build_pred_next;
            build_count_reg <= build_count_next;
            build_set_reg <= build_set_next;
            build_way_reg <= build_way_next;
            hit_cnt_reg <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            lfsr_reg <= lfsr_next;
            mod_val_reg <= mod_val_next;
            clr_reg <= clr_next;
            res_reg <= res_next;
            out_reg <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/trace_cache_lookup_and_fill_core.sv
// Top level of the trace cache lookup and fill core with its register port.
// A fetched instruction enters a two-entry queue and is processed by a sequencer that works on
// the line memories one transaction at a time. A plain instruction passes from the idle state
// to the output state, through the commit write state when it completes a trace. A branch
// passes through the compare state to the output state on a hit or when a free way exists, and
// on an eviction through one more state that reduces the replacement LFSR value modulo WAYS;
// committing an open trace first adds the commit write state and a second read of the set, as
// the line memories have a single read port. The sequencer holds in the output state until the
// previous result has been taken. After reset the valid bits are cleared one set per cycle over
// all 2**floor(log2(SETS)) sets, during which no instruction is accepted; register writes are
// taken throughout.
`default_nettype none
module trace_cache_lookup_and_fill_core #(
    parameter int SETS      = 64,
    parameter int WAYS      = 4,
    parameter int ADDR_BITS = 32,
    parameter int MAX_LEN   = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tclf_in_if.sink          fetch,
    tclf_out_if.source       result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [5:0]  max_insns_reg;
    logic [15:0] lfsr_seed_reg;
    logic        wr_en;
    logic        sel_seed;
    logic        q_valid;
    logic        q_pop;
    logic        busy_clear;
    tclf_pkg::item_t q_item;
    tclf_pkg::cfg_t  cfg;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign sel_seed = (paddr[2] == 1'(tclf_pkg::REG_LFSR_SEED));
    assign prdata = sel_seed ? {16'd0, lfsr_seed_reg} : {26'd0, max_insns_reg};

    always_comb
    begin
        priority if (max_insns_reg < 6'd2)
        begin
            cfg.limit = 6'd2;
        end
        else if (max_insns_reg > 6'(MAX_LEN))
        begin
            cfg.limit = 6'(MAX_LEN);
        end
        else
        begin
            cfg.limit = max_insns_reg;
        end
        cfg.seed_load = wr_en && sel_seed;
        cfg.seed = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_insns_reg <= 6'd16;
            lfsr_seed_reg <= 16'd1;
        end
        else if (wr_en)
        begin
            if (sel_seed)
            begin
                lfsr_seed_reg <= pwdata[15:0];
            end
            else
            begin
                max_insns_reg <= pwdata[5:0];
            end
        end
    end

    tclf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .fetch      (fetch),
        .busy_clear (busy_clear),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    tclf_back #(
        .SETS      (SETS),
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .busy_clear (busy_clear),
        .cfg        (cfg),
        .result     (result)
    );
endmodule
`default_nettype wire

// File: tb/tclf_checker.sv
// Checker that predicts every lookup result from observed transactions and compares it.
`timescale 1ns / 1ps
module tclf_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tclf_in_if               fetch,
    tclf_out_if              result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic        pready,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output int               fail_count,
    output int               pending,
    output int               seen_results,
    output int               seen_hits,
    output int               seen_commits,
    output int               seen_evictions
);

    localparam int WAYS = 4;
    localparam int LINES = 256;

    logic [31:0] line_tag [LINES];
    logic        line_pred [LINES];
    logic        line_valid [LINES];
    logic [5:0]  line_length [LINES];
    logic        building;
    logic [31:0] build_tag;
    logic        build_pred;
    logic [5:0]  build_count;
    logic [7:0]  build_slot;
    logic [31:0] hit_counter;
    logic [31:0] miss_counter;
    logic [15:0] replace_lfsr;
    logic [5:0]  max_insns;
    tclf_pkg::res_t expected_results [$];

    function automatic logic [5:0] trace_limit();
        if (max_insns < 6'd2)
            return 6'd2;
        if (max_insns > 6'd32)
            return 6'd32;
        return max_insns;
    endfunction

    task automatic commit_trace(inout tclf_pkg::res_t r);
        line_tag[build_slot] = build_tag;
        line_pred[build_slot] = build_pred;
        line_length[build_slot] = build_count;
        line_valid[build_slot] = 1'b1;
        r.trace_written = 1'b1;
        r.written_slot = build_slot;
        r.written_length = build_count;
        building = 1'b0;
        build_count = '0;
        build_slot = '0;
    endtask

    task automatic predict_fetch(input logic [31:0] addr, input tclf_pkg::kind_t kind,
                                 input logic pred, output tclf_pkg::res_t r);
        logic [7:0] base;
        int         pick;
        logic       found;
        logic       lsb;
        r = '0;
        found = 1'b0;
        if (kind == tclf_pkg::KIND_BRANCH)
        begin
            if (building)
                commit_trace(r);
            r.looked_up = 1'b1;
            base = {addr[5:0], 2'b00};
            for (int w = 0; w < WAYS; w++)
            begin
                if (!found && line_valid[base + w] && line_tag[base + w] == addr
                    && line_pred[base + w] == pred)
                begin
                    found = 1'b1;
                    r.hit = 1'b1;
                    r.hit_length = line_length[base + w];
                end
            end
            if (found)
            begin
                hit_counter++;
            end
            else
            begin
                miss_counter++;
                pick = WAYS;
                for (int w = WAYS - 1; w >= 0; w--)
                    if (!line_valid[base + w])
                        pick = w;
                if (pick == WAYS)
                begin
                    lsb = replace_lfsr[0];
                    replace_lfsr = replace_lfsr >> 1;
                    if (lsb)
                        replace_lfsr ^= tclf_pkg::LFSR_TAPS;
                    pick = replace_lfsr % WAYS;
                    seen_evictions++;
                end
                build_slot = base + 8'(pick);
                build_tag = addr;
                build_pred = pred;
                build_count = 6'd1;
                building = 1'b1;
                if (build_count >= trace_limit())
                    commit_trace(r);
            end
        end
        else if (building)
        begin
            build_count++;
            if (build_count >= trace_limit())
                commit_trace(r);
        end
        r.hit_total = hit_counter;
        r.miss_total = miss_counter;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tclf_pkg::res_t r;
        if (!rst_n)
        begin
            for (int i = 0; i < LINES; i++)
            begin
                line_tag[i] = '0;
                line_pred[i] = 1'b0;
                line_valid[i] = 1'b0;
                line_length[i] = '0;
            end
            building = 1'b0;
            build_tag = '0;
            build_pred = 1'b0;
            build_count = '0;
            build_slot = '0;
            hit_counter = '0;
            miss_counter = '0;
            replace_lfsr = 16'd1;
            max_insns = 6'd16;
            expected_results.delete();
            fail_count = 0;
            seen_results = 0;
            seen_hits = 0;
            seen_commits = 0;
            seen_evictions = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual slot %0h",
                             $time, result.written_slot);
                    fail_count++;
                end
                else
                begin
                    r = expected_results.pop_front();
                    compare_field("looked_up", r.looked_up, result.looked_up);
                    compare_field("hit", r.hit, result.hit);
                    compare_field("hit_length", r.hit_length, result.hit_length);
                    compare_field("trace_written", r.trace_written, result.trace_written);
                    compare_field("written_slot", r.written_slot, result.written_slot);
                    compare_field("written_length", r.written_length, result.written_length);
                    compare_field("hit_total", r.hit_total, result.hit_total);
                    compare_field("miss_total", r.miss_total, result.miss_total);
                    seen_results++;
                    seen_hits += r.hit;
                    seen_commits += r.trace_written;
                end
            end
            if (fetch.valid && fetch.ready)
            begin
                predict_fetch(fetch.fetch_addr, tclf_pkg::kind_t'(fetch.is_branch),
                              fetch.branch_pred, r);
                expected_results.push_back(r);
            end
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == 3'(4 * tclf_pkg::REG_MAX_INSNS))
                    max_insns = pwdata[5:0];
                else if (paddr == 3'(4 * tclf_pkg::REG_LFSR_SEED))
                    replace_lfsr = (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
            end
        end
        pending = expected_results.size();
    end

endmodule

// File: tb/trace_cache_lookup_and_fill_core_test.sv
// Top of the trace cache testbench: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 1ps
module trace_cache_lookup_and_fill_core_test;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE = 40;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          seen_results;
    int          seen_hits;
    int          seen_commits;
    int          seen_evictions;
    int          cycles;
    int          sent;
    logic        calm;
    logic        long_hold;
    logic [31:0] addr_pool [12];

    tclf_in_if  fetch ();
    tclf_out_if result ();

    trace_cache_lookup_and_fill_core DUT (
        .clk(clk), .rst_n(rst_n), .fetch(fetch), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tclf_checker u_checker (
        .clk(clk), .rst_n(rst_n), .fetch(fetch), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .pending(pending),
        .seen_results(seen_results), .seen_hits(seen_hits), .seen_commits(seen_commits),
        .seen_evictions(seen_evictions)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int gap;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                result.ready = 1'b0;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
            end
            gap = calm ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                result.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            result.ready = 1'b1;
            do @(posedge clk); while (!result.valid);
        end
    end

    task automatic send_fetch(input logic [31:0] addr, input tclf_pkg::kind_t kind,
                              input logic pred);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            fetch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        fetch.valid = 1'b1;
        fetch.fetch_addr = addr;
        fetch.is_branch = kind;
        fetch.branch_pred = pred;
        do @(posedge clk); while (!fetch.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic write_register(input int unsigned index, input logic [31:0] value);
        fetch.valid = 1'b0;
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 3'(4 * index);
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic drain();
        fetch.valid = 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_phase(input int count);
        int done;
        int run;
        done = 0;
        while (done < count)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                send_fetch($urandom, tclf_pkg::kind_t'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
                done++;
            end
            else
            begin
                send_fetch(addr_pool[$urandom_range(0, 11)], tclf_pkg::KIND_BRANCH,
                           1'($urandom_range(0, 1)));
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40)
                                                   : $urandom_range(0, 6);
                done += run + 1;
                repeat (run) send_fetch($urandom, tclf_pkg::KIND_PLAIN,
                                        1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 99) == 0)
                calm = ~calm;
        end
    endtask

    initial
    begin
        logic [31:0] tag_high;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fetch.valid = 1'b0;
        fetch.fetch_addr = '0;
        fetch.is_branch = 1'b0;
        fetch.branch_pred = 1'b0;
        calm = 1'b0;
        long_hold = 1'b0;
        sent = 0;
        for (int i = 0; i < 12; i++)
        begin
            tag_high = $urandom;
            addr_pool[i] = {tag_high[31:6], (i < 6) ? 6'd5 : (i < 10) ? 6'd17 : 6'd63};
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_fetch(32'h0000_0000, tclf_pkg::KIND_PLAIN, 1'b0);
        send_fetch(32'h0000_0040, tclf_pkg::KIND_BRANCH, 1'b0);
        repeat (3) send_fetch(32'h0000_0044, tclf_pkg::KIND_PLAIN, 1'b1);
        send_fetch(32'h0000_0040, tclf_pkg::KIND_BRANCH, 1'b0);
        send_fetch(32'h0000_0040, tclf_pkg::KIND_BRANCH, 1'b1);
        send_fetch(32'h0000_0080, tclf_pkg::KIND_BRANCH, 1'b0);
        send_fetch(32'h0000_00C0, tclf_pkg::KIND_BRANCH, 1'b0);
        send_fetch(32'h0000_0100, tclf_pkg::KIND_BRANCH, 1'b0);
        send_fetch(32'h0000_0140, tclf_pkg::KIND_BRANCH, 1'b1);
        send_fetch(32'hFFFF_FFFF, tclf_pkg::KIND_BRANCH, 1'b1);
        repeat (8) send_fetch(32'hFFFF_FFFF, tclf_pkg::KIND_PLAIN, 1'b0);
        send_fetch(32'hFFFF_FFFF, tclf_pkg::KIND_BRANCH, 1'b1);
        send_fetch(32'h0000_0000, tclf_pkg::KIND_BRANCH, 1'b0);
        drain();

        write_register(tclf_pkg::REG_MAX_INSNS, 32'd0);
        write_register(tclf_pkg::REG_LFSR_SEED, 32'd0);
        random_phase(380);
        drain();

        write_register(tclf_pkg::REG_MAX_INSNS, 32'd2);
        write_register(tclf_pkg::REG_LFSR_SEED, 32'hFFFF);
        long_hold = 1'b1;
        random_phase(380);
        drain();

        write_register(tclf_pkg::REG_MAX_INSNS, 32'd63);
        write_register(tclf_pkg::REG_LFSR_SEED, 32'hACE1);
        random_phase(380);
        drain();

        write_register(tclf_pkg::REG_MAX_INSNS, 32'd32);
        write_register(tclf_pkg::REG_LFSR_SEED, $urandom_range(1, 65535));
        random_phase(380);
        drain();

        write_register(tclf_pkg::REG_MAX_INSNS, 32'd1);
        write_register(tclf_pkg::REG_LFSR_SEED, 32'd1);
        random_phase(200);
        drain();
        write_register(tclf_pkg::REG_MAX_INSNS, $urandom_range(3, 31));
        random_phase(200);
        drain();

        $display("Sent %0d fetched instructions under seven register settings.", sent);
        $display("Checked %0d results: %0d hits, %0d trace writes, %0d evictions.",
                 seen_results, seen_hits, seen_commits, seen_evictions);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tclf_pkg.sv
rtl/tclf_if.sv
rtl/tclf_ram.sv
rtl/tclf_front.sv
rtl/tclf_back.sv
rtl/trace_cache_lookup_and_fill_core.sv
tb/tclf_checker.sv
tb/trace_cache_lookup_and_fill_core_test.sv
